[sv/ptm_pkg.sv]
// Shared types, constants and helper functions for the page table map engine.
// No dependencies; every other file but ptm_ram.sv refers to this package.
package ptm_pkg;

  localparam int NUM_TABLES_DEF = 16;
  localparam int ENTRY_W = 64;
  localparam int IDX_W = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [63:0] FRAME_FIELD = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] KEEP_FIELD = 64'hFFF0_0000_0000_0FFF;
  localparam logic [39:0] FRAME_MASK = 40'hFF_FFFF_FFFF;
  localparam logic [63:0] LINK_FLAGS = 64'h7;
  localparam logic [63:0] USER_FLAG = 64'h4;
  localparam logic [2:0] LEAF_LVL = 3'd4;

  localparam logic [2:0] OP_MAP = 3'd0;
  localparam logic [2:0] OP_UMAP = 3'd1;
  localparam logic [2:0] OP_HMAP = 3'd2;
  localparam logic [2:0] OP_UNMAP = 3'd3;
  localparam logic [2:0] OP_SETF = 3'd4;
  localparam logic [2:0] OP_CLRF = 3'd5;
  localparam logic [2:0] OP_REMAP = 3'd6;
  localparam logic [2:0] OP_NONE = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_FIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_HH, ST_RD, ST_EV, ST_REL, ST_ZERO, ST_LINK, ST_LEAF, ST_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

  // Index slice of a virtual address for walk level 0 (bit 48) to 4 (bit 12).
  function automatic logic [IDX_W-1:0] idx_of(input logic [63:0] va, input logic [2:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      3'd0:    r = va[56:48];
      3'd1:    r = va[47:39];
      3'd2:    r = va[38:30];
      3'd3:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

endpackage

[sv/ptm_if.sv]
// Handshake interfaces for the request, result and configuration channels.
// Depends on ptm_pkg for field widths.
interface ptm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [63:0] virt_addr;
  logic [63:0] new_virt_addr;
  logic [63:0] phys_addr;
  logic [63:0] flag_bits;
  modport source (output valid, operation, virt_addr, new_virt_addr, phys_addr, flag_bits,
                  input ready);
  modport sink (input valid, operation, virt_addr, new_virt_addr, phys_addr, flag_bits,
                output ready);
endinterface

interface ptm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] leaf_entry;
  logic [51:0] old_phys_addr;
  logic        pool_exhausted;
  modport source (output valid, leaf_entry, old_phys_addr, pool_exhausted, input ready);
  modport sink (input valid, leaf_entry, old_phys_addr, pool_exhausted, output ready);
endinterface

interface ptm_cfg_if;
  logic        valid;
  logic        ready;
  logic [ptm_pkg::CFG_IDX_W-1:0] reg_index;
  logic [63:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

[sv/ptm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ptm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[sv/ptm_alu.sv]
// Shared 64-bit add/subtract unit used for address offsets and frame math.
// Depends on ptm_pkg for the request struct.
module ptm_alu (
  input  ptm_pkg::alu_req_t req,
  output logic [63:0]       res
);
  import ptm_pkg::*;
  always_comb begin
    res = req.sub ? (req.a - req.b) : (req.a + req.b);
  end
endmodule

[sv/page_table_map_engine.sv]
// Page table map engine: radix page table walker with table allocation.
// Each upper level reads its entry, then follows the link, clears a fresh table and links it,
// or ends with the pool exhausted; the leaf is then read and rewritten and the result presented.
// Five-level mode adds a level, a higher-half map first adds the offset, and a remap walks twice.
// Throughput: one item at a time, the next taken the cycle after the result. After reset the
// whole store is cleared; no item is taken then.
module page_table_map_engine #(
  parameter int NUM_TABLES = ptm_pkg::NUM_TABLES_DEF
) (
  input logic clk,
  input logic rst_n,
  ptm_in_if.sink    in_ch,
  ptm_out_if.source out_ch,
  ptm_cfg_if.sink   cfg_ch
);
  import ptm_pkg::*;

  localparam int TW = $clog2(NUM_TABLES);
  localparam int NW = $clog2(NUM_TABLES + 1);
  localparam int DEPTH = NUM_TABLES * 512;
  localparam int AW = $clog2(DEPTH);

  state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] nf_r, nf_nxt;
  logic [TW-1:0] tbl_r, tbl_nxt;
  logic [2:0] lvl_r, lvl_nxt, op_r, op_nxt;
  logic phase_r, phase_nxt, exh_r, exh_nxt;
  logic [63:0] va_r, va_nxt, nva_r, nva_nxt, pa_r, pa_nxt, flags_r, flags_nxt;
  logic [63:0] ent_r, ent_nxt, leaf_r, leaf_nxt;
  logic [39:0] rel_r, rel_nxt;
  logic [51:0] old_r, old_nxt;
  logic five_r;
  logic [63:0] off_r;
  logic [39:0] base_r;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata, rdata, alu_res, lv;
  alu_req_t alu_req;
  logic [AW-1:0] slot;
  logic [2:0] start_lvl;

  ptm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  ptm_alu u_alu (.req(alu_req), .res(alu_res));

  assign slot = {tbl_r, idx_of(va_r, lvl_r)};
  assign start_lvl = five_r ? 3'd0 : 3'd1;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.leaf_entry = leaf_r;
  assign out_ch.old_phys_addr = old_r;
  assign out_ch.pool_exhausted = exh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      five_r <= 1'b0;
      off_r <= '0;
      base_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_FIVE:   five_r <= cfg_ch.wdata[0];
        CFG_OFFSET: off_r <= cfg_ch.wdata;
        CFG_BASE:   base_r <= cfg_ch.wdata[39:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r <= '0;
      nf_r <= NW'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      nf_r <= nf_nxt;
    end
    tbl_r <= tbl_nxt; lvl_r <= lvl_nxt; op_r <= op_nxt; phase_r <= phase_nxt;
    exh_r <= exh_nxt; va_r <= va_nxt; nva_r <= nva_nxt; pa_r <= pa_nxt;
    flags_r <= flags_nxt; ent_r <= ent_nxt; leaf_r <= leaf_nxt; rel_r <= rel_nxt;
    old_r <= old_nxt;
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; nf_nxt = nf_r; tbl_nxt = tbl_r;
    lvl_nxt = lvl_r; op_nxt = op_r; phase_nxt = phase_r; exh_nxt = exh_r;
    va_nxt = va_r; nva_nxt = nva_r; pa_nxt = pa_r; flags_nxt = flags_r;
    ent_nxt = ent_r; leaf_nxt = leaf_r; rel_nxt = rel_r; old_nxt = old_r;
    we = 1'b0; waddr = slot; wdata = '0; re = 1'b0; raddr = slot;
    alu_req = '{a: pa_r, b: off_r, sub: 1'b0};
    lv = '0;
    unique case (state_r)
      ST_CLR: begin
        we = 1'b1;
        waddr = cnt_r;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt = in_ch.operation;
          va_nxt = in_ch.virt_addr;
          nva_nxt = in_ch.new_virt_addr;
          pa_nxt = in_ch.phys_addr;
          flags_nxt = in_ch.flag_bits;
          leaf_nxt = '0; old_nxt = '0; exh_nxt = 1'b0; phase_nxt = 1'b0;
          tbl_nxt = '0; lvl_nxt = start_lvl;
          if (in_ch.operation == OP_NONE) begin
            state_nxt = ST_OUT;
          end else if (in_ch.operation == OP_HMAP) begin
            state_nxt = ST_HH;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_HH: begin
        va_nxt = alu_res;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        re = 1'b1;
        state_nxt = (lvl_r == LEAF_LVL) ? ST_LEAF : ST_EV;
      end
      ST_EV: begin
        alu_req = '{a: {24'h0, rdata[51:12]}, b: {24'h0, base_r}, sub: 1'b1};
        ent_nxt = rdata;
        if (rdata[0]) begin
          rel_nxt = alu_res[39:0];
          state_nxt = ST_REL;
        end else if (nf_r >= NW'(NUM_TABLES)) begin
          exh_nxt = 1'b1; leaf_nxt = '0;
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = '0;
          state_nxt = ST_ZERO;
        end
      end
      ST_REL: begin
        if (rel_r >= 40'(NUM_TABLES)) begin
          exh_nxt = 1'b1; leaf_nxt = '0;
          state_nxt = ST_OUT;
        end else begin
          tbl_nxt = rel_r[TW-1:0];
          lvl_nxt = lvl_r + 3'd1;
          state_nxt = ST_RD;
        end
      end
      ST_ZERO: begin
        // Fresh table is cleared before the link entry goes in.
        we = 1'b1;
        waddr = {nf_r[TW-1:0], cnt_r[IDX_W-1:0]};
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r[IDX_W-1:0] == '1) begin
          state_nxt = ST_LINK;
        end
      end
      ST_LINK: begin
        alu_req = '{a: {24'h0, base_r}, b: 64'(nf_r), sub: 1'b0};
        we = 1'b1;
        wdata = (ent_r & KEEP_FIELD) | {12'h0, alu_res[39:0] & FRAME_MASK, 12'h0} | LINK_FLAGS;
        tbl_nxt = nf_r[TW-1:0];
        nf_nxt = nf_r + NW'(1);
        lvl_nxt = lvl_r + 3'd1;
        state_nxt = ST_RD;
      end
      ST_LEAF: begin
        we = 1'b1;
        state_nxt = ST_OUT;
        case (op_r) inside
          OP_MAP, OP_HMAP: lv = (rdata & KEEP_FIELD) | (pa_r & FRAME_FIELD) | flags_r;
          OP_UMAP: lv = (rdata & KEEP_FIELD) | (pa_r & FRAME_FIELD) | flags_r | USER_FLAG;
          OP_SETF: lv = rdata | flags_r;
          OP_CLRF: lv = rdata & ~flags_r;
          OP_REMAP: begin
            if (phase_r) begin
              lv = (rdata & KEEP_FIELD) | (pa_r & FRAME_FIELD) | flags_r;
            end else begin
              // Old leaf is cleared, then the walk restarts at the new address.
              lv = '0;
              old_nxt = rdata[51:0] & FRAME_FIELD[51:0];
              pa_nxt = rdata & FRAME_FIELD;
              va_nxt = nva_r;
              phase_nxt = 1'b1;
              tbl_nxt = '0;
              lvl_nxt = start_lvl;
              state_nxt = ST_RD;
            end
          end
          default: lv = '0;
        endcase
        wdata = lv;
        leaf_nxt = lv;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while a result is pending");
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.pool_exhausted |-> out_ch.leaf_entry == 64'h0)
    else $error("exhausted result with nonzero leaf");
  a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= NW'(NUM_TABLES) && nf_r != '0) else $error("free table counter out of range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("ready right after accept");

endmodule

[tb/sv/ptm_checker.sv]
// Checker for the page table map engine: watches the request and result channels,
// predicts each result with its own page table model, and counts mismatches.
// Depends on ptm_pkg and the channel interfaces in ptm_if.sv.
`timescale 1ns / 1ps
module ptm_checker #(
  parameter int NUM_TABLES = ptm_pkg::NUM_TABLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ptm_in_if.sink      in_mon,
  ptm_out_if.sink     out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import ptm_pkg::*;

  typedef struct packed {
    logic [63:0] leaf;
    logic [51:0] old_pa;
    logic        exhausted;
  } map_result_t;

  logic [63:0] pt_mem [NUM_TABLES*512];
  int unsigned free_tbl;
  logic        five_lvl;
  logic [63:0] hh_offset;
  logic [39:0] base_frame;
  map_result_t result_q[$];

  function automatic logic [63:0] set_frame(logic [63:0] e, logic [63:0] fr);
    return (e & KEEP_FIELD) | ({24'b0, fr[39:0]} << 12);
  endfunction

  function automatic bit walk_to_leaf(logic [63:0] va, output int unsigned pos);
    int unsigned tbl, slot;
    logic [63:0] e;
    logic [39:0] rel;
    tbl = 0;
    pos = 0;
    for (int lvl = (five_lvl ? 0 : 1); lvl < 4; lvl++) begin
      slot = tbl * 512 + idx_of(va, lvl[2:0]);
      e = pt_mem[slot];
      if (e[0]) begin
        rel = e[51:12] - base_frame;
        if (rel >= NUM_TABLES) return 0;
        tbl = 32'(rel);
      end else begin
        if (free_tbl >= NUM_TABLES) return 0;
        for (int k = 0; k < 512; k++) pt_mem[free_tbl*512 + k] = '0;
        pt_mem[slot] = set_frame(e, {24'b0, base_frame + 40'(free_tbl)}) | LINK_FLAGS;
        tbl = free_tbl;
        free_tbl++;
      end
    end
    pos = tbl * 512 + idx_of(va, LEAF_LVL);
    return 1;
  endfunction

  function automatic bit map_page(logic [63:0] va, logic [63:0] pa, logic [63:0] fl,
                                  output logic [63:0] leaf);
    int unsigned pos;
    leaf = '0;
    if (!walk_to_leaf(va, pos)) return 0;
    pt_mem[pos] = set_frame(pt_mem[pos], pa >> 12) | fl;
    leaf = pt_mem[pos];
    return 1;
  endfunction

  function automatic map_result_t predict_request(logic [2:0] op, logic [63:0] va,
      logic [63:0] nva, logic [63:0] pa, logic [63:0] fl);
    map_result_t r;
    int unsigned pos;
    bit ok;
    logic [63:0] leaf, old;
    leaf = '0;
    old = '0;
    ok = 1;
    case (op)
      OP_MAP:   ok = map_page(va, pa, fl, leaf);
      OP_UMAP:  ok = map_page(va, pa, fl | USER_FLAG, leaf);
      OP_HMAP:  ok = map_page(pa + hh_offset, pa, fl, leaf);
      OP_UNMAP: begin
        ok = walk_to_leaf(va, pos);
        if (ok) pt_mem[pos] = '0;
      end
      OP_SETF: begin
        ok = walk_to_leaf(va, pos);
        if (ok) begin
          pt_mem[pos] |= fl;
          leaf = pt_mem[pos];
        end
      end
      OP_CLRF: begin
        ok = walk_to_leaf(va, pos);
        if (ok) begin
          pt_mem[pos] &= ~fl;
          leaf = pt_mem[pos];
        end
      end
      OP_REMAP: begin
        ok = walk_to_leaf(va, pos);
        if (ok) begin
          old = pt_mem[pos] & FRAME_FIELD;
          pt_mem[pos] = '0;
          ok = map_page(nva, old, fl, leaf);
        end
      end
      default: ;
    endcase
    if (!ok) leaf = '0;
    r.leaf = leaf;
    r.old_pa = old[51:0];
    r.exhausted = !ok;
    return r;
  endfunction

  always @(posedge clk) begin
    map_result_t exp_r;
    if (!rst_n) begin
      for (int k = 0; k < NUM_TABLES*512; k++) pt_mem[k] = '0;
      free_tbl = 1;
      five_lvl = 0;
      hh_offset = '0;
      base_frame = '0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FIVE:   five_lvl = cfg_data[0];
          CFG_OFFSET: hh_offset = cfg_data;
          CFG_BASE:   base_frame = cfg_data[39:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        result_q.push_back(predict_request(in_mon.operation, in_mon.virt_addr,
            in_mon.new_virt_addr, in_mon.phys_addr, in_mon.flag_bits));
      if (out_mon.valid && out_mon.ready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item, nothing pending");
        end else begin
          exp_r = result_q.pop_front();
          if (exp_r.leaf !== out_mon.leaf_entry || exp_r.old_pa !== out_mon.old_phys_addr ||
              exp_r.exhausted !== out_mon.pool_exhausted) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected leaf %h old %h exh %b, got leaf %h old %h exh %b",
                       exp_r.leaf, exp_r.old_pa, exp_r.exhausted, out_mon.leaf_entry,
                       out_mon.old_phys_addr, out_mon.pool_exhausted);
          end
        end
      end
    end
    pending = result_q.size();
  end
endmodule

[tb/sv/tb_page_table_map_engine.sv]
// Top of the page table map engine testbench: clock, reset, request and register stimulus,
// and the verdict. Depends on ptm_pkg, ptm_if.sv, ptm_checker and the engine itself.
`timescale 1ns / 1ps
module tb_page_table_map_engine;
  import ptm_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending;
  int   idle_cycles = 0;
  bit   calm = 0;
  bit   hold_off = 0;

  ptm_in_if  in_ch();
  ptm_out_if out_ch();
  ptm_cfg_if cfg_ch();

  page_table_map_engine dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink),
                             .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink));

  ptm_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
                   .cfg_we(cfg_ch.valid && cfg_ch.ready), .cfg_idx(cfg_ch.reg_index),
                   .cfg_data(cfg_ch.wdata), .fail_count(fail_count), .pending(pending));

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.operation = OP_MAP;
    in_ch.virt_addr = '0;
    in_ch.new_virt_addr = '0;
    in_ch.phys_addr = '0;
    in_ch.flag_bits = '0;
    cfg_ch.valid = 0;
    cfg_ch.reg_index = CFG_FIVE;
    cfg_ch.wdata = '0;
    out_ch.ready = 0;
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off.
  always @(posedge clk) begin
    if (hold_off) out_ch.ready <= 0;
    else if (calm) out_ch.ready <= 1;
    else out_ch.ready <= ($urandom_range(99) >= 22);
  end

  // Watchdog: cycles with no accepted item at all. Table allocation clears whole tables, which
  // makes some items slow, so the limit is generous.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("page_table_map_engine test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_request(logic [2:0] op, logic [63:0] va, logic [63:0] nva,
                              logic [63:0] pa, logic [63:0] fl);
    while (!calm && $urandom_range(99) < 22) @(posedge clk);
    in_ch.valid <= 1;
    in_ch.operation <= op;
    in_ch.virt_addr <= va;
    in_ch.new_virt_addr <= nva;
    in_ch.phys_addr <= pa;
    in_ch.flag_bits <= fl;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Addresses drawn from a few slices so walks reuse tables and the pool stays useful.
  function automatic logic [63:0] pick_va();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(9) < 8) begin
      v[56:21] = {9'($urandom_range(1)), 9'($urandom_range(1)), 9'($urandom_range(1)),
                  9'($urandom_range(1))};
      v[20:12] = 9'($urandom_range(7));
    end
    return v;
  endfunction

  task automatic random_phase(int n);
    logic [63:0] fl;
    for (int i = 0; i < n; i++) begin
      fl = {$urandom, $urandom};
      if ($urandom_range(3) != 0) fl = fl & 64'h8000_0000_0000_0FFF;
      send_request(3'($urandom_range(7)), pick_va(), pick_va(), {$urandom, $urandom}, fl);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: every operation and field extremes, then exhaust the pool.
    send_request(OP_MAP, '0, '0, '0, '0);
    send_request(OP_MAP, '1, '1, '1, '1);
    send_request(OP_UMAP, 64'h1000, '0, 64'h000F_FFFF_FFFF_F000, 64'h2);
    send_request(OP_HMAP, '0, '0, 64'h5000, 64'h3);
    send_request(OP_SETF, 64'h1000, '0, '0, 64'h8000_0000_0000_0010);
    send_request(OP_CLRF, 64'h1000, '0, '0, 64'h2);
    send_request(OP_REMAP, 64'h1000, 64'h2000, '0, 64'h1);
    send_request(OP_UNMAP, 64'h2000, '0, '0, '0);
    send_request(OP_NONE, '1, '1, '1, '1);
    send_request(OP_REMAP, 64'hAAAA_5555_AAAA_5000, '1, '0, '0);
    for (int i = 0; i < 6; i++)
      send_request(OP_MAP, {$urandom, $urandom}, '0, {$urandom, $urandom}, 64'h1);
    send_request(OP_REMAP, 64'h1000, {$urandom, $urandom}, '0, 64'h1);
    drain();
    write_reg(CFG_FIVE, 64'h1);
    write_reg(CFG_OFFSET, '1);
    write_reg(CFG_BASE, 64'hFF_FFFF_FFFF);
    // Tables are exhausted; new base makes existing links fall outside the pool.
    send_request(OP_MAP, '0, '0, '0, '0);
    send_request(OP_HMAP, '0, '0, 64'h1000, '0);
    send_request(OP_SETF, '1, '0, '0, '1);
    random_phase(60);
    drain();
    write_reg(CFG_BASE, '0);
    write_reg(CFG_FIVE, '0);
    write_reg(CFG_OFFSET, 64'hFFFF_8000_0000_0000);
    calm = 1;
    random_phase(120);
    calm = 0;
    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      random_phase(40);
    join
    drain();
    write_reg(CFG_FIVE, 64'h1);
    write_reg(CFG_BASE, 64'h12_3456_7000);
    random_phase(160);
    drain();
    write_reg(CFG_FIVE, '0);
    write_reg(CFG_OFFSET, '0);
    random_phase(160);
    drain();
    if (fail_count == 0) $display("page_table_map_engine test passed");
    else $display("page_table_map_engine test failed");
    $finish;
  end
endmodule
